>>> rtl/barometric_pressure_compensation_assert.svh
// assertion macros for the barometric pressure compensation block
// used by the top level only, expects clk and rst_n in scope
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bpc_pkg.sv
// shared types, widths and constants of the pressure compensation pipeline
// no dependencies
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DW    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_P1    = 4'd0,
        IDX_P2    = 4'd1,
        IDX_P3    = 4'd2,
        IDX_P4    = 4'd3,
        IDX_P5    = 4'd4,
        IDX_P6    = 4'd5,
        IDX_P7    = 4'd6,
        IDX_P8_P9 = 4'd7
    } reg_idx_t;

    localparam logic [15:0] RST_P1    = 16'd36477;
    localparam logic [15:0] RST_P2    = 16'd54851;
    localparam logic [15:0] RST_P3    = 16'd3024;
    localparam logic [15:0] RST_P4    = 16'd2855;
    localparam logic [15:0] RST_P5    = 16'd140;
    localparam logic [15:0] RST_P6    = 16'd65529;
    localparam logic [15:0] RST_P7    = 16'd15500;
    localparam logic [31:0] RST_P8_P9 = 32'd393266936;

    // datapath widths
    localparam int D_W    = 21;
    localparam int DD_W   = 42;
    localparam int P2_W   = 58;
    localparam int P1_W   = 37;
    localparam int OFF_W  = 60;
    localparam int X_W    = 52;
    localparam int XC_W   = 69;
    localparam int NUM_W  = 61;
    localparam int DIV_W  = 36;
    localparam int N_W    = 74;
    localparam int Q_W    = 37;
    localparam int P_W    = 38;

    localparam logic signed [D_W-1:0] T_OFFSET = 21'sd128000;
    localparam logic [20:0]           ONE_M    = 21'h100000;
    localparam logic signed [12:0]    SCALE    = 13'sd3125;
    localparam logic [Q_W-1:0]        PSAT_MAG = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [19:0]           PMAX     = 20'hFFFFF;

    typedef struct packed {
        logic [15:0]        c1;
        logic signed [15:0] c2;
        logic signed [15:0] c3;
        logic signed [15:0] c4;
        logic signed [15:0] c5;
        logic signed [15:0] c6;
        logic signed [15:0] c7;
        logic signed [15:0] c8;
        logic signed [15:0] c9;
    } cal_t;

    typedef struct packed {
        logic           valid;
        logic           dz;
        logic           neg;
        logic [N_W-1:0] nmag;
        logic [DIV_W-1:0] dmag;
    } front_out_t;

    typedef struct packed {
        logic           valid;
        logic           dz;
        logic           neg;
        logic           ovf;
        logic [Q_W-1:0] q;
    } div_out_t;

endpackage

>>> rtl/barometric_pressure_compensation.sv
// top level of the barometric pressure compensation pipeline
// depends on bpc_pkg, bpc_front, bpc_div, bpc_back and the assertion header
`timescale 1ns / 1ps

// channel   ports                                  handshake
// -------   -----------------------------------    ------------------------------
// request   start, busy, raw_pressure,             taken when start && !busy
//           fine_temperature
// result    done, pressure_pa, divisor_zero        one-cycle strobe on done
// config    cfg_we, cfg_index, cfg_wdata           written when cfg_we is high
//
// a request enters every cycle; the divider produces one quotient bit
// per stage (37 steps plus a setup stage)
// busy never rises, the pipeline has no stall path; the receiver cannot stall
// reset clears valid bits and loads the calibration defaults
// config is to be written only while nothing is in flight; the user must keep to this, the block does not enforce it

module barometric_pressure_compensation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [19:0]                     raw_pressure,
    input  logic signed [19:0]              fine_temperature,
    output logic                            done,
    output logic [19:0]                     pressure_pa,
    output logic                            divisor_zero,
    input  logic                            cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::CFG_DW-1:0]      cfg_wdata
);

    `include "barometric_pressure_compensation_assert.svh"

    // calibration registers
    logic [15:0] cal_p1_reg, cal_p2_reg, cal_p3_reg, cal_p4_reg;
    logic [15:0] cal_p5_reg, cal_p6_reg, cal_p7_reg;
    logic [31:0] cal_p8_p9_reg;

    bpc_pkg::cal_t       cal;
    bpc_pkg::front_out_t front_out;
    bpc_pkg::div_out_t   div_out;
    logic                in_valid;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_p1_reg    <= bpc_pkg::RST_P1;
            cal_p2_reg    <= bpc_pkg::RST_P2;
            cal_p3_reg    <= bpc_pkg::RST_P3;
            cal_p4_reg    <= bpc_pkg::RST_P4;
            cal_p5_reg    <= bpc_pkg::RST_P5;
            cal_p6_reg    <= bpc_pkg::RST_P6;
            cal_p7_reg    <= bpc_pkg::RST_P7;
            cal_p8_p9_reg <= bpc_pkg::RST_P8_P9;
        end
        else if (cfg_we)
        begin
            // indexes past the list are dropped
            unique case (cfg_index)
                bpc_pkg::IDX_P1:    cal_p1_reg    <= cfg_wdata[15:0];
                bpc_pkg::IDX_P2:    cal_p2_reg    <= cfg_wdata[15:0];
                bpc_pkg::IDX_P3:    cal_p3_reg    <= cfg_wdata[15:0];
                bpc_pkg::IDX_P4:    cal_p4_reg    <= cfg_wdata[15:0];
                bpc_pkg::IDX_P5:    cal_p5_reg    <= cfg_wdata[15:0];
                bpc_pkg::IDX_P6:    cal_p6_reg    <= cfg_wdata[15:0];
                bpc_pkg::IDX_P7:    cal_p7_reg    <= cfg_wdata[15:0];
                bpc_pkg::IDX_P8_P9: cal_p8_p9_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // coefficient eight low half, nine high half
    assign cal.c1 = cal_p1_reg;
    assign cal.c2 = $signed(cal_p2_reg);
    assign cal.c3 = $signed(cal_p3_reg);
    assign cal.c4 = $signed(cal_p4_reg);
    assign cal.c5 = $signed(cal_p5_reg);
    assign cal.c6 = $signed(cal_p6_reg);
    assign cal.c7 = $signed(cal_p7_reg);
    assign cal.c8 = $signed(cal_p8_p9_reg[15:0]);
    assign cal.c9 = $signed(cal_p8_p9_reg[31:16]);

    // offset, divisor and scaled numerator, then magnitudes and sign
    bpc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .raw_pressure     (raw_pressure),
        .fine_temperature (fine_temperature),
        .cal              (cal),
        .fo               (front_out)
    );

    // one quotient bit per stage
    bpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .fi    (front_out),
        .dout  (div_out)
    );

    // saturate, second-order correction, whole pascals, clamp
    bpc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .di           (div_out),
        .cal          (cal),
        .done         (done),
        .pressure_pa  (pressure_pa),
        .divisor_zero (divisor_zero)
    );

    // a zero divisor always reports zero pressure
    `BPC_ASSERT_IMP(a_dz_zero, done && divisor_zero, pressure_pa == '0, "zero divisor with nonzero pressure")

    // the result strobe follows the divider hand-off through the back-end valid pipeline and the done register
    `BPC_ASSERT_IMP(a_back_latency, 1'b1, done == $past(div_out.valid, 4), "result strobe out of step with divider")

    // a write to coefficient one lands in its register
    `BPC_ASSERT_NXT(a_cfg_p1, cfg_we && (cfg_index == bpc_pkg::IDX_P1), cal_p1_reg == $past(cfg_wdata[15:0]), "coefficient one write lost")

endmodule

>>> rtl/bpc_front.sv
// front pipeline: offset and divisor polynomials, numerator, magnitudes
// depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [19:0]         raw_pressure,
    input  logic signed [19:0]  fine_temperature,
    input  bpc_pkg::cal_t       cal,
    output bpc_pkg::front_out_t fo
);

    logic [5:0] v_reg;

    // stage 1
    logic signed [bpc_pkg::D_W-1:0]  d_next;
    logic signed [bpc_pkg::DD_W-1:0] dd_next;
    logic signed [bpc_pkg::D_W-1:0]  d1_reg;
    logic signed [bpc_pkg::DD_W-1:0] dd1_reg;
    logic [19:0]                     adc1_reg;

    // stage 2
    logic signed [bpc_pkg::P2_W-1:0] ddc6_reg, ddc3_reg;
    logic signed [bpc_pkg::P1_W-1:0] dc5_reg, dc2_reg;
    logic [19:0]                     adc2_reg;

    // stage 3
    logic signed [bpc_pkg::OFF_W-1:0] off_next, off3_reg;
    logic signed [bpc_pkg::X_W-1:0]   x_next, x3_reg;
    logic [19:0]                      adc3_reg;

    // stage 4
    logic [20:0]                      span;
    logic signed [bpc_pkg::XC_W-1:0]  xc_next, xc4_reg;
    logic signed [bpc_pkg::NUM_W-1:0] num_next, num4_reg;

    // stage 5
    logic signed [bpc_pkg::DIV_W-1:0] div5_reg;
    logic signed [bpc_pkg::N_W-1:0]   n_next, n5_reg;

    // stage 6
    logic                             neg6_reg, dz6_reg;
    logic [bpc_pkg::N_W-1:0]          nmag6_reg;
    logic [bpc_pkg::DIV_W-1:0]        dmag6_reg;

    assign d_next   = $signed({fine_temperature[19], fine_temperature}) - bpc_pkg::T_OFFSET;
    assign dd_next  = bpc_pkg::DD_W'(d_next) * bpc_pkg::DD_W'(d_next);

    assign off_next = bpc_pkg::OFF_W'(ddc6_reg)
                    + (bpc_pkg::OFF_W'(dc5_reg) <<< 17)
                    + (bpc_pkg::OFF_W'(cal.c4) <<< 35);
    assign x_next   = bpc_pkg::X_W'(ddc3_reg >>> 8)
                    + (bpc_pkg::X_W'(dc2_reg) <<< 12)
                    + (bpc_pkg::X_W'(1) <<< 47);

    assign span     = bpc_pkg::ONE_M - {1'b0, adc3_reg};
    assign xc_next  = bpc_pkg::XC_W'(x3_reg) * bpc_pkg::XC_W'($signed({1'b0, cal.c1}));
    assign num_next = (bpc_pkg::NUM_W'($signed({1'b0, span})) <<< 31)
                    - bpc_pkg::NUM_W'(off3_reg);

    assign n_next   = bpc_pkg::N_W'(num4_reg) * bpc_pkg::N_W'(bpc_pkg::SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg    <= d_next;
        dd1_reg   <= dd_next;
        adc1_reg  <= raw_pressure;

        ddc6_reg  <= bpc_pkg::P2_W'(dd1_reg) * bpc_pkg::P2_W'(cal.c6);
        ddc3_reg  <= bpc_pkg::P2_W'(dd1_reg) * bpc_pkg::P2_W'(cal.c3);
        dc5_reg   <= bpc_pkg::P1_W'(d1_reg) * bpc_pkg::P1_W'(cal.c5);
        dc2_reg   <= bpc_pkg::P1_W'(d1_reg) * bpc_pkg::P1_W'(cal.c2);
        adc2_reg  <= adc1_reg;

        off3_reg  <= off_next;
        x3_reg    <= x_next;
        adc3_reg  <= adc2_reg;

        xc4_reg   <= xc_next;
        num4_reg  <= num_next;

        div5_reg  <= bpc_pkg::DIV_W'(xc4_reg >>> 33);
        n5_reg    <= n_next;

        neg6_reg  <= n5_reg[bpc_pkg::N_W-1] ^ div5_reg[bpc_pkg::DIV_W-1];
        dz6_reg   <= (div5_reg == '0);
        nmag6_reg <= n5_reg[bpc_pkg::N_W-1] ? bpc_pkg::N_W'(-n5_reg) : bpc_pkg::N_W'(n5_reg);
        dmag6_reg <= div5_reg[bpc_pkg::DIV_W-1] ? bpc_pkg::DIV_W'(-div5_reg)
                                                : bpc_pkg::DIV_W'(div5_reg);
    end

    assign fo.valid = v_reg[5];
    assign fo.dz    = dz6_reg;
    assign fo.neg   = neg6_reg;
    assign fo.nmag  = nmag6_reg;
    assign fo.dmag  = dmag6_reg;

endmodule

>>> rtl/bpc_div.sv
// pipelined restoring divider, one quotient bit per stage, overflow detect
// depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  bpc_pkg::front_out_t fi,
    output bpc_pkg::div_out_t   dout
);

    localparam int QW = bpc_pkg::Q_W;
    localparam int DW = bpc_pkg::DIV_W;

    logic          v_reg   [0:QW];
    logic          dz_reg  [0:QW];
    logic          neg_reg [0:QW];
    logic          ovf_reg [0:QW];
    logic [DW-1:0] dm_reg  [0:QW];
    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] qn_reg  [0:QW];

    // quotient would not fit in the bits produced: saturate downstream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= fi.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dz_reg[0]  <= fi.dz;
        neg_reg[0] <= fi.neg;
        ovf_reg[0] <= fi.nmag[bpc_pkg::N_W-1:QW] >= {1'b0, fi.dmag};
        dm_reg[0]  <= fi.dmag;
        rem_reg[0] <= fi.nmag[QW+DW-1:QW];
        qn_reg[0]  <= fi.nmag[QW-1:0];
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;

        assign trial = {rem_reg[k], qn_reg[k][QW-1]};
        assign ge    = trial >= {1'b0, dm_reg[k]};
        assign diff  = trial - {1'b0, dm_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dz_reg[k+1]  <= dz_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            dm_reg[k+1]  <= dm_reg[k];
            rem_reg[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            qn_reg[k+1]  <= {qn_reg[k][QW-2:0], ge};
        end
    end

    assign dout.valid = v_reg[QW];
    assign dout.dz    = dz_reg[QW];
    assign dout.neg   = neg_reg[QW];
    assign dout.ovf   = ovf_reg[QW];
    assign dout.q     = qn_reg[QW];

endmodule

>>> rtl/bpc_back.sv
// back pipeline: saturation, second-order correction, scaling and clamp
// depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bpc_pkg::div_out_t di,
    input  bpc_pkg::cal_t     cal,
    output logic              done,
    output logic [19:0]       pressure_pa,
    output logic              divisor_zero
);

    localparam int PW   = bpc_pkg::P_W;
    localparam int A_W  = PW - 13;
    localparam int AA_W = 2 * A_W;
    localparam int C8_W = PW + 16;
    localparam int K1P_W = AA_W + 16;
    localparam int K2_W = C8_W - 19;
    localparam int K1_W = K1P_W - 25;
    localparam int S_W  = 44;

    logic [2:0] v_reg;
    logic       done_reg;

    logic [bpc_pkg::Q_W-1:0] qs;
    logic signed [PW-1:0]    p_next, p1_reg, p2_reg, p3_reg;
    logic                    dz1_reg, dz2_reg, dz3_reg;

    logic signed [A_W-1:0]   a;
    logic signed [AA_W-1:0]  aa2_reg;
    logic signed [C8_W-1:0]  c8p2_reg;

    logic signed [K1P_W-1:0] k1p3_reg;
    logic signed [K2_W-1:0]  k2_3_reg;

    logic signed [K1_W-1:0]  k1;
    logic signed [S_W-1:0]   sum;
    logic signed [S_W-1:0]   s;
    logic [S_W-1:0]          s_scaled;
    logic [19:0]             pres_next, pres_reg;
    logic                    dzo_reg;

    assign qs     = (di.ovf || (di.q > bpc_pkg::PSAT_MAG)) ? bpc_pkg::PSAT_MAG : di.q;
    assign p_next = di.neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});

    assign a = A_W'(p1_reg >>> 13);

    assign k1  = K1_W'(k1p3_reg >>> 25);
    assign sum = S_W'(p3_reg) + S_W'(k1) + S_W'(k2_3_reg);
    assign s   = (sum >>> 8) + (S_W'(cal.c7) <<< 4);
    assign s_scaled = S_W'(s) >> 8;

    always_comb
    begin
        if (dz3_reg || s[S_W-1])
        begin
            pres_next = '0;
        end
        else if (s_scaled > S_W'(bpc_pkg::PMAX))
        begin
            pres_next = bpc_pkg::PMAX;
        end
        else
        begin
            pres_next = s_scaled[19:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[1:0], di.valid};
            done_reg <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p_next;
        dz1_reg  <= di.dz;

        aa2_reg  <= AA_W'(a) * AA_W'(a);
        c8p2_reg <= C8_W'(p1_reg) * C8_W'(cal.c8);
        p2_reg   <= p1_reg;
        dz2_reg  <= dz1_reg;

        k1p3_reg <= K1P_W'(aa2_reg) * K1P_W'(cal.c9);
        k2_3_reg <= K2_W'(c8p2_reg >>> 19);
        p3_reg   <= p2_reg;
        dz3_reg  <= dz2_reg;

        pres_reg <= pres_next;
        dzo_reg  <= dz3_reg;
    end

    assign done         = done_reg;
    assign pressure_pa  = pres_reg;
    assign divisor_zero = dzo_reg;

endmodule
